// ===== rtl/core/gbp_pkg.sv =====
// shared types, constants and codes for the gshare btb predictor
`default_nettype none
package gbp_pkg;

	localparam int HISTORY_BITS_DEF   = 8;
	localparam int BTB_INDEX_BITS_DEF = 10;
	localparam int QUEUE_DEPTH        = 2;
	localparam int PC_BITS            = 64;

	localparam logic [PC_BITS-1:0] PC_STEP = 64'd4;

	// operation codes
	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_UPDATE  = 1'b1;

	// branch kind codes
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_COND   = 2'd1;
	localparam logic [1:0] KIND_UNCOND = 2'd2;

	// 2-bit saturating counter states
	localparam logic [1:0] CTR_STRONG_NT = 2'd0;
	localparam logic [1:0] CTR_WEAK_T    = 2'd2;
	localparam logic [1:0] CTR_STRONG_T  = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FINISH
	} back_state_t;

	// one classified word on its way from front to back
	typedef struct packed {
		logic               is_update;
		logic               is_cond;
		logic               taken;
		logic [PC_BITS-1:0] pc;
		logic [PC_BITS-1:0] actual;
	} item_t;

	typedef struct packed {
		logic clearing;
		logic popped_predict;
	} back_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/gbp_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module gbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/gbp_front.sv =====
// front end: takes input words and classifies them for the queue
`default_nettype none
module gbp_front
	import gbp_pkg::*;
(
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               operation,
	input  wire logic [PC_BITS-1:0] insn_pc,
	input  wire logic [PC_BITS-1:0] resolved_pc,
	input  wire logic               branch_taken,
	input  wire logic [1:0]         branch_kind,
	input  wire logic               q_full,
	output logic                    push,
	output item_t                   push_item
);

	logic is_branch;

	assign in_ready  = !q_full;
	// non-branch updates change nothing, so they are dropped here
	assign is_branch = (branch_kind == KIND_COND) || (branch_kind == KIND_UNCOND);
	assign push      = in_valid && in_ready && ((operation == OP_PREDICT) || is_branch);

	always_comb begin
		push_item.is_update = (operation == OP_UPDATE);
		push_item.is_cond   = (branch_kind == KIND_COND);
		push_item.taken     = branch_taken;
		push_item.pc        = insn_pc;
		push_item.actual    = resolved_pc;
	end

endmodule
`default_nettype wire

// ===== rtl/core/gbp_queue.sv =====
// short fifo between front and back
`default_nettype none
module gbp_queue
	import gbp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output logic       head_valid,
	output item_t      head_item
);

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

	item_t               mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/gbp_back.sv =====
// back end: btb and counter table lookup, training and result register
`default_nettype none
module gbp_back
	import gbp_pkg::*;
#(
	parameter int HISTORY_BITS   = HISTORY_BITS_DEF,
	parameter int BTB_INDEX_BITS = BTB_INDEX_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               head_valid,
	input  wire item_t              head_item,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [PC_BITS-1:0]      next_pc,
	output logic                    btb_miss,
	output back_status_t            status
);

	localparam int BTB_DEPTH = 2 ** BTB_INDEX_BITS;
	localparam int PHT_DEPTH = 2 ** HISTORY_BITS;
	localparam int CLR_BITS  = (BTB_INDEX_BITS > HISTORY_BITS) ? BTB_INDEX_BITS : HISTORY_BITS;
	localparam int META_BITS = 2;
	localparam int DATA_BITS = 2 * PC_BITS;

	back_state_t state_q, state_d;
	logic [CLR_BITS-1:0]     clr_q;
	logic [HISTORY_BITS-1:0] history_q;
	item_t                   item_s1;
	logic [HISTORY_BITS-1:0] pht_idx_s1;
	logic                    out_valid_q;
	logic [PC_BITS-1:0]      next_pc_q;
	logic                    miss_q;
	logic                    go;

	// ram ports
	logic                      meta_we, meta_re;
	logic [BTB_INDEX_BITS-1:0] meta_waddr, btb_raddr;
	logic [META_BITS-1:0]      meta_wdata, meta_rdata;
	logic                      data_we;
	logic [DATA_BITS-1:0]      data_wdata, data_rdata;
	logic                      pht_we;
	logic [HISTORY_BITS-1:0]   pht_waddr, pht_raddr;
	logic [1:0]                pht_wdata, pht_rdata;

	// lookup results in the finish cycle
	logic [BTB_INDEX_BITS-1:0] btb_idx_s1;
	logic                      hit;
	logic [PC_BITS-1:0]        old_target;
	logic [PC_BITS-1:0]        pc_plus4;
	logic [PC_BITS-1:0]        new_target;
	logic [1:0]                ctr_next;

	gbp_ram #(.WIDTH(META_BITS), .DEPTH(BTB_DEPTH)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (btb_raddr),
		.rdata (meta_rdata)
	);

	gbp_ram #(.WIDTH(DATA_BITS), .DEPTH(BTB_DEPTH)) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (btb_idx_s1),
		.wdata (data_wdata),
		.re    (meta_re),
		.raddr (btb_raddr),
		.rdata (data_rdata)
	);

	gbp_ram #(.WIDTH(2), .DEPTH(PHT_DEPTH)) u_pht_ram (
		.clk   (clk),
		.we    (pht_we),
		.waddr (pht_waddr),
		.wdata (pht_wdata),
		.re    (meta_re),
		.raddr (pht_raddr),
		.rdata (pht_rdata)
	);

	// a predict needs the result register free by the finish cycle
	assign go = head_valid && (head_item.is_update || !out_valid_q || out_ready);

	assign btb_raddr  = head_item.pc[BTB_INDEX_BITS+1:2];
	assign pht_raddr  = history_q ^ head_item.pc[HISTORY_BITS+1:2];
	assign btb_idx_s1 = item_s1.pc[BTB_INDEX_BITS+1:2];

	assign hit        = meta_rdata[1] && (data_rdata[DATA_BITS-1:PC_BITS] == item_s1.pc);
	assign old_target = data_rdata[PC_BITS-1:0];
	assign pc_plus4   = item_s1.pc + PC_STEP;

	always_comb begin
		if (item_s1.taken) begin
			new_target = item_s1.actual;
		end else if (meta_rdata[1]) begin
			new_target = old_target;
		end else begin
			new_target = pc_plus4;
		end
	end

	always_comb begin
		ctr_next = pht_rdata;
		if (item_s1.taken) begin
			if (pht_rdata != CTR_STRONG_T) begin
				ctr_next = pht_rdata + 2'd1;
			end
		end else begin
			if (pht_rdata != CTR_STRONG_NT) begin
				ctr_next = pht_rdata - 2'd1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (go) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		pop        = 1'b0;
		meta_re    = 1'b0;
		meta_we    = 1'b0;
		meta_waddr = btb_idx_s1;
		meta_wdata = {1'b1, item_s1.is_cond};
		data_we    = 1'b0;
		data_wdata = {item_s1.pc, new_target};
		pht_we     = 1'b0;
		pht_waddr  = pht_idx_s1;
		pht_wdata  = ctr_next;
		case (state_q)
			ST_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = clr_q[BTB_INDEX_BITS-1:0];
				meta_wdata = '0;
				pht_we     = 1'b1;
				pht_waddr  = clr_q[HISTORY_BITS-1:0];
				pht_wdata  = CTR_STRONG_NT;
			end
			ST_IDLE: begin
				pop     = go;
				meta_re = go;
			end
			ST_FINISH: begin
				meta_we = item_s1.is_update;
				data_we = item_s1.is_update;
				pht_we  = item_s1.is_update && item_s1.is_cond;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			history_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if ((state_q == ST_FINISH) && item_s1.is_update && item_s1.is_cond) begin
				history_q <= {history_q[HISTORY_BITS-2:0], item_s1.taken};
			end
			if ((state_q == ST_FINISH) && !item_s1.is_update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && (state_q == ST_IDLE)) begin
			item_s1    <= head_item;
			pht_idx_s1 <= pht_raddr;
		end
		if ((state_q == ST_FINISH) && !item_s1.is_update) begin
			next_pc_q <= (hit && (!meta_rdata[0] || (pht_rdata >= CTR_WEAK_T)))
				? old_target : pc_plus4;
			miss_q    <= !hit;
		end
	end

	assign out_valid = out_valid_q;
	assign next_pc   = next_pc_q;
	assign btb_miss  = miss_q;

	assign status.clearing       = (state_q == ST_CLEAR);
	assign status.popped_predict = pop && !head_item.is_update;

endmodule
`default_nettype wire

// ===== rtl/core/gshare_btb_branch_predictor.sv =====
// top level: gshare direction predictor with a direct-mapped btb
// a predict word goes from the queue through the idle read and the finish state to the result register
// the back end takes a new word only after finishing the last, due to the read-then-write of the btb rams
// non-branch update words are dropped at the front and cost the back end nothing
// reset: asynchronous; a clearing pass over every address of the larger of the btb and the counter
// table wipes btb valid bits and counters; words queue up but wait for it
`default_nettype none
module gshare_btb_branch_predictor
	import gbp_pkg::*;
#(
	parameter int HISTORY_BITS   = HISTORY_BITS_DEF,
	parameter int BTB_INDEX_BITS = BTB_INDEX_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               operation,
	input  wire logic [PC_BITS-1:0] insn_pc,
	input  wire logic [PC_BITS-1:0] resolved_pc,
	input  wire logic               branch_taken,
	input  wire logic [1:0]         branch_kind,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [PC_BITS-1:0]      next_pc,
	output logic                    btb_miss
);

	// front to queue
	logic  q_push;
	item_t q_push_item;
	logic  q_full;
	// queue to back
	logic  q_pop;
	logic  q_head_valid;
	item_t q_head_item;
	back_status_t back_status;

	// front classifies each word: predicts and real branch updates go on
	gbp_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.insn_pc      (insn_pc),
		.resolved_pc  (resolved_pc),
		.branch_taken (branch_taken),
		.branch_kind  (branch_kind),
		.q_full       (q_full),
		.push         (q_push),
		.push_item    (q_push_item)
	);

	// decoupling queue so the front keeps taking words while the back trains, until the queue is full
	gbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_item  (q_head_item)
	);

	// back end: ram read in the idle state, then resolve and write back in the finish state
	gbp_back #(
		.HISTORY_BITS   (HISTORY_BITS),
		.BTB_INDEX_BITS (BTB_INDEX_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_item  (q_head_item),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.next_pc    (next_pc),
		.btb_miss   (btb_miss),
		.status     (back_status)
	);

	// no result can come out while the stores are being cleared
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.clearing |-> !out_valid)
		else $error("result word during clearing pass");

	// queue never written when full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("queue overflow");

	// back end only pops a word that is there
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head_valid)
		else $error("queue underflow");

	// every predict taken by the back end lands in the result register
	a_predict_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.popped_predict |-> ##2 out_valid)
		else $error("predict word lost");

endmodule
`default_nettype wire
